@@ rtl/bimfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bimfa_pkg
// shared widths, command codes and fixed-point constants of the byte adder
// ----------------------------------------------------------------------------
`default_nettype none

package bimfa_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 4;
    localparam int EXP_W  = 3;
    localparam int MAN_W  = 4;

    // command codes
    localparam logic CMD_INT_ADD   = 1'b0;
    localparam logic CMD_FLOAT_ADD = 1'b1;

    // significand held at 1.0 = 4096: hidden one, mantissa, eight guard bits
    localparam int FRAC_SHIFT = 8;
    localparam int FIX_W      = 1 + MAN_W + FRAC_SHIFT;
    localparam int SUM_W      = FIX_W + 1;
    localparam int ONE_FIX    = 1 << (FIX_W - 1);
    localparam int TWO_FIX    = 2 * ONE_FIX;
    localparam int TRUNC_BIAS = (1 << FRAC_SHIFT) - 1;

endpackage

`default_nettype wire

@@ rtl/byte_int_and_minifloat_adder_top.sv @@
// ----------------------------------------------------------------------------
// byte_int_and_minifloat_adder_top
// byte adder with a two's-complement mode and an eight-bit minifloat mode
// ----------------------------------------------------------------------------
// A command is taken on every clock edge at which start is high; busy is
// never raised, so one transaction per cycle is sustained indefinitely. Each
// command is captured in an input register, the integer or float sum is
// formed by one pass of combinational logic, and the result is held in an
// output register: o_valid strobes for exactly one cycle, once the command
// has passed both registers, together with o_dest_index and o_sum_byte. The
// receiver cannot stall, so it must take every strobed result. Integer mode
// wraps modulo 256. Float mode reads bit 7 as sign, bits 6-4 as a raw
// exponent and bits 3-0 as the fraction under a hidden one; it aligns
// exactly, normalises by a single step, truncates the fraction and lets the
// exponent wrap. There is no stored state other than the pipeline itself.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_int_and_minifloat_adder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_command,
    input  logic [bimfa_pkg::IDX_W-1:0]  i_dest_reg,
    input  logic [bimfa_pkg::BYTE_W-1:0] i_value_s,
    input  logic [bimfa_pkg::BYTE_W-1:0] i_value_t,
    output logic                         o_valid,
    output logic [bimfa_pkg::IDX_W-1:0]  o_dest_index,
    output logic [bimfa_pkg::BYTE_W-1:0] o_sum_byte
);
    import bimfa_pkg::*;

    // input stage
    logic              r_in_valid;
    logic              r_cmd;
    logic [IDX_W-1:0]  r_dest;
    logic [BYTE_W-1:0] r_s, r_t;

    // result stage
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_dest;
    logic [BYTE_W-1:0] r_out_sum;

    logic              n_in_valid;
    logic [BYTE_W-1:0] n_out_sum;
    logic [BYTE_W-1:0] int_sum, flt_sum;

    // never stalls: a new command every cycle
    assign busy       = 1'b0;
    assign n_in_valid = start && !busy;

    // input register, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (n_in_valid) begin
            r_cmd  <= i_command;
            r_dest <= i_dest_reg;
            r_s    <= i_value_s;
            r_t    <= i_value_t;
        end
    end

    // integer path, wraps modulo 256
    assign int_sum = r_s + r_t;

    bimfa_fadd u_fadd (
        .i_s   (r_s),
        .i_t   (r_t),
        .o_sum (flt_sum)
    );

    always_comb begin
        case (r_cmd)
            CMD_FLOAT_ADD: n_out_sum = flt_sum;
            default:       n_out_sum = int_sum;
        endcase
    end

    // result register, strobe lasts a single cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out_dest <= r_dest;
            r_out_sum  <= n_out_sum;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_dest_index = r_out_dest;
    assign o_sum_byte   = r_out_sum;

    // every accepted command shows up after the input and result registers
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted command produced no result");

    // no result without a command accepted ahead of it through both registers
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result strobe without a command");

    // destination index travels with its command
    a_dest : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dest_index == $past(i_dest_reg, 2)))
        else $error("destination index mismatch");

    // integer mode gives the wrapped byte sum
    a_int_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_command, 2) == CMD_INT_ADD)) |->
        (o_sum_byte == ($past(i_value_s, 2) + $past(i_value_t, 2))))
        else $error("integer sum mismatch");

endmodule

`default_nettype wire

@@ rtl/bimfa_fadd.sv @@
// ----------------------------------------------------------------------------
// bimfa_fadd
// combinational eight-bit minifloat add: align, add or subtract, one-step
// normalise, truncate and pack
// ----------------------------------------------------------------------------
`default_nettype none

module bimfa_fadd (
    input  logic [bimfa_pkg::BYTE_W-1:0] i_s,
    input  logic [bimfa_pkg::BYTE_W-1:0] i_t,
    output logic [bimfa_pkg::BYTE_W-1:0] o_sum
);
    import bimfa_pkg::*;

    logic             sign_s, sign_t, sign_r;
    logic [EXP_W-1:0] exp_s, exp_t, exp_big, exp_r, shift;
    logic [FIX_W-1:0] man_s, man_t, man_s_al, man_t_al, norm;
    logic [SUM_W-1:0] sig_sum, diff, adj;
    logic [MAN_W-1:0] man_field;

    always_comb begin
        sign_s = i_s[BYTE_W-1];
        sign_t = i_t[BYTE_W-1];
        exp_s  = i_s[BYTE_W-2 -: EXP_W];
        exp_t  = i_t[BYTE_W-2 -: EXP_W];
        man_s  = {1'b1, i_s[MAN_W-1:0], {FRAC_SHIFT{1'b0}}};
        man_t  = {1'b1, i_t[MAN_W-1:0], {FRAC_SHIFT{1'b0}}};

        // align the smaller exponent onto the larger one
        if (exp_s > exp_t) begin
            shift    = exp_s - exp_t;
            man_s_al = man_s;
            man_t_al = man_t >> shift;
            exp_big  = exp_s;
        end else begin
            shift    = exp_t - exp_s;
            man_s_al = man_s >> shift;
            man_t_al = man_t;
            exp_big  = exp_t;
        end

        // magnitude add or subtract, t wins the sign on a tie
        if (sign_s == sign_t) begin
            sig_sum = {1'b0, man_s_al} + {1'b0, man_t_al};
            sign_r  = sign_s;
        end else if (man_s_al > man_t_al) begin
            sig_sum = {1'b0, man_s_al - man_t_al};
            sign_r  = sign_s;
        end else begin
            sig_sum = {1'b0, man_t_al - man_s_al};
            sign_r  = sign_t;
        end

        // single normalisation step, exponent wraps
        if (sig_sum >= SUM_W'(TWO_FIX)) begin
            norm  = sig_sum[SUM_W-1:1];
            exp_r = exp_big + EXP_W'(1);
        end else if (sig_sum < SUM_W'(ONE_FIX)) begin
            norm  = {sig_sum[FIX_W-2:0], 1'b0};
            exp_r = exp_big - EXP_W'(1);
        end else begin
            norm  = sig_sum[FIX_W-1:0];
            exp_r = exp_big;
        end

        // fraction field, truncated toward zero, then kept modulo 16
        diff      = {1'b0, norm} - SUM_W'(ONE_FIX);
        adj       = diff + (diff[SUM_W-1] ? SUM_W'(TRUNC_BIAS) : SUM_W'(0));
        man_field = adj[FRAC_SHIFT +: MAN_W];

        o_sum = {sign_r, exp_r, man_field};
    end

endmodule

`default_nettype wire

@@ tb/byte_int_and_minifloat_adder_top_test.sv @@
// ----------------------------------------------------------------------------
// byte_int_and_minifloat_adder_top_test
// self-checking bench for the byte adder, integer and minifloat modes
// ----------------------------------------------------------------------------
// A queue of add commands is filled up front: a short directed list first,
// then random commands. A clocked driver presents them on the start/busy
// handshake with random gaps. A clocked monitor takes every strobed result and
// compares it with the oldest predicted result. The prediction is a local
// model of both add modes, worked out when a command is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_int_and_minifloat_adder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bimfa_pkg::*;

    // run length guard, far above the slowest legal run
    localparam int LIMIT_CYCLES  = 20000;
    localparam int N_RANDOM      = 650;
    localparam int SETTLE_CYCLES = 8;
    // the sender waits for the pipeline to empty once at this point
    localparam int DRAIN_POINT   = 120;
    // no random gaps while the accepted count is from QUIET_FROM to below QUIET_TO
    localparam int QUIET_FROM    = 250;
    localparam int QUIET_TO      = 400;
    // significand scale used by the float prediction: 1.0 = 4096
    localparam int UNIT_SIG      = 4096;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  dest;
        logic [BYTE_W-1:0] val_s;
        logic [BYTE_W-1:0] val_t;
    } add_cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  dest;
        logic [BYTE_W-1:0] sum;
    } add_result_t;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              start        = 1'b0;
    logic              i_command    = CMD_INT_ADD;
    logic [IDX_W-1:0]  i_dest_reg   = '0;
    logic [BYTE_W-1:0] i_value_s    = '0;
    logic [BYTE_W-1:0] i_value_t    = '0;
    logic              busy;
    logic              o_valid;
    logic [IDX_W-1:0]  o_dest_index;
    logic [BYTE_W-1:0] o_sum_byte;

    add_cmd_t    pending_cmds[$];
    add_result_t predicted_sums[$];

    int cycle_count  = 0;
    int n_accepted   = 0;
    int n_int        = 0;
    int n_float      = 0;
    int n_checked    = 0;
    int n_failures   = 0;
    bit drained_once = 1'b0;

    byte_int_and_minifloat_adder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_dest_reg   (i_dest_reg),
        .i_value_s    (i_value_s),
        .i_value_t    (i_value_t),
        .o_valid      (o_valid),
        .o_dest_index (o_dest_index),
        .o_sum_byte   (o_sum_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // minifloat sum: sign, raw 3-bit exponent, 4-bit fraction under a hidden one
    function automatic logic [BYTE_W-1:0] minifloat_sum(logic [BYTE_W-1:0] a,
                                                        logic [BYTE_W-1:0] b);
        logic     sign_a, sign_b, sign_r;
        int       exp_a, exp_b, exp_r;
        int       sig_a, sig_b, sig_r, excess, frac;
        logic [2:0] exp_bits;
        logic [3:0] frac_bits;
        sign_a = a[7];
        sign_b = b[7];
        exp_a  = int'(a[6:4]);
        exp_b  = int'(b[6:4]);
        sig_a  = (16 + int'(a[3:0])) * 256;
        sig_b  = (16 + int'(b[3:0])) * 256;
        // align the smaller exponent, exactly at this scale
        if (exp_a > exp_b) begin
            sig_b = sig_b >> (exp_a - exp_b);
            exp_r = exp_a;
        end else begin
            sig_a = sig_a >> (exp_b - exp_a);
            exp_r = exp_b;
        end
        // unlike signs: larger magnitude decides, a tie goes to the t operand
        if (sign_a == sign_b) begin
            sig_r  = sig_a + sig_b;
            sign_r = sign_a;
        end else if (sig_a > sig_b) begin
            sig_r  = sig_a - sig_b;
            sign_r = sign_a;
        end else begin
            sig_r  = sig_b - sig_a;
            sign_r = sign_b;
        end
        // a single normalising step in either direction
        if (sig_r >= 2 * UNIT_SIG) begin
            sig_r = sig_r >> 1;
            exp_r = exp_r + 1;
        end else if (sig_r < UNIT_SIG) begin
            sig_r = sig_r << 1;
            exp_r = exp_r - 1;
        end
        // truncate toward zero; a negative fraction wraps modulo 16
        excess    = sig_r - UNIT_SIG;
        frac      = excess / 256;
        frac_bits = frac[3:0];
        exp_bits  = exp_r[2:0];
        return {sign_r, exp_bits, frac_bits};
    endfunction

    function automatic add_result_t predict_result(add_cmd_t c);
        add_result_t r;
        r.dest = c.dest;
        if (c.cmd == CMD_FLOAT_ADD)
            r.sum = minifloat_sum(c.val_s, c.val_t);
        else
            r.sum = c.val_s + c.val_t;
        return r;
    endfunction

    task automatic queue_cmd(logic cmd, logic [IDX_W-1:0] dest,
                             logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] t);
        add_cmd_t c;
        c.cmd   = cmd;
        c.dest  = dest;
        c.val_s = s;
        c.val_t = t;
        pending_cmds.push_back(c);
    endtask

    // cycle count, reset release and the run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 8)
            i_rst_n <= 1'b1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** byte_int_and_minifloat_adder_top: FAILED **");
            $finish;
        end
    end

    // driver: one transaction per accepted edge, random gaps between them
    always @(posedge i_clk) begin
        add_cmd_t next_cmd;
        bit       gap;
        bit       hold;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                // push the prediction before popping so the end check never
                // sees both queues empty in between
                predicted_sums.push_back(predict_result(pending_cmds[0]));
                if (pending_cmds[0].cmd == CMD_FLOAT_ADD)
                    n_float++;
                else
                    n_int++;
                void'(pending_cmds.pop_front());
                n_accepted++;
            end
            // once, let every outstanding result come back before going on
            if (!drained_once && n_accepted >= DRAIN_POINT && predicted_sums.size() == 0)
                drained_once = 1'b1;
            hold = !drained_once && n_accepted >= DRAIN_POINT;
            gap  = ($urandom_range(0, 99) < 26) &&
                   !(n_accepted >= QUIET_FROM && n_accepted < QUIET_TO);
            if (pending_cmds.size() != 0 && !gap && !hold) begin
                next_cmd   = pending_cmds[0];
                start      <= 1'b1;
                i_command  <= next_cmd.cmd;
                i_dest_reg <= next_cmd.dest;
                i_value_s  <= next_cmd.val_s;
                i_value_t  <= next_cmd.val_t;
            end else begin
                // idle: start low, payload is noise
                start      <= 1'b0;
                i_command  <= 1'($urandom_range(0, 1));
                i_dest_reg <= IDX_W'($urandom_range(0, 15));
                i_value_s  <= BYTE_W'($urandom_range(0, 255));
                i_value_t  <= BYTE_W'($urandom_range(0, 255));
            end
        end
    end

    // monitor: every strobe is a result, matched against the oldest prediction
    always @(posedge i_clk) begin
        add_result_t want;
        if (i_rst_n && o_valid) begin
            if (predicted_sums.size() == 0) begin
                $error("result with nothing outstanding: dest_index %0d sum_byte 0x%02h",
                       o_dest_index, o_sum_byte);
                n_failures++;
            end else begin
                want = predicted_sums.pop_front();
                n_checked++;
                if (o_dest_index !== want.dest) begin
                    $error("dest_index: expected %0d, got %0d", want.dest, o_dest_index);
                    n_failures++;
                end
                if (o_sum_byte !== want.sum) begin
                    $error("sum_byte: expected 0x%02h, got 0x%02h", want.sum, o_sum_byte);
                    n_failures++;
                end
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] s, t;
        logic [2:0]        e;
        logic              cmd;
        int                mode;

        // integer mode: zero, signed overflow, both carries, all ones
        queue_cmd(CMD_INT_ADD, 4'd0,  8'h00, 8'h00);
        queue_cmd(CMD_INT_ADD, 4'd15, 8'h7F, 8'h01);
        queue_cmd(CMD_INT_ADD, 4'd0,  8'h80, 8'h80);
        queue_cmd(CMD_INT_ADD, 4'd15, 8'hFF, 8'hFF);
        queue_cmd(CMD_INT_ADD, 4'd5,  8'hFF, 8'h01);
        queue_cmd(CMD_INT_ADD, 4'd10, 8'h55, 8'hAA);
        // float mode: like signs giving two or more, halved once
        queue_cmd(CMD_FLOAT_ADD, 4'd0,  8'h00, 8'h00);
        queue_cmd(CMD_FLOAT_ADD, 4'd15, 8'hFF, 8'h8F);
        // exponent running past seven wraps
        queue_cmd(CMD_FLOAT_ADD, 4'd1,  8'h7F, 8'h7F);
        // unlike signs, equal magnitudes: t decides the sign
        queue_cmd(CMD_FLOAT_ADD, 4'd2,  8'h3A, 8'hBA);
        queue_cmd(CMD_FLOAT_ADD, 4'd3,  8'hBA, 8'h3A);
        // unlike signs, s larger then t larger
        queue_cmd(CMD_FLOAT_ADD, 4'd4,  8'h45, 8'hC2);
        queue_cmd(CMD_FLOAT_ADD, 4'd6,  8'h42, 8'hC5);
        // sum below one, doubled once
        queue_cmd(CMD_FLOAT_ADD, 4'd7,  8'h1F, 8'h90);
        // still below one after doubling: fraction goes negative and wraps
        queue_cmd(CMD_FLOAT_ADD, 4'd8,  8'h11, 8'h90);
        // below one at exponent zero: exponent wraps downwards
        queue_cmd(CMD_FLOAT_ADD, 4'd9,  8'h0F, 8'h80);
        // widest alignment shifts, both ways and with unlike signs
        queue_cmd(CMD_FLOAT_ADD, 4'd11, 8'h70, 8'h00);
        queue_cmd(CMD_FLOAT_ADD, 4'd12, 8'h00, 8'h7F);
        queue_cmd(CMD_FLOAT_ADD, 4'd13, 8'h70, 8'h80);
        queue_cmd(CMD_FLOAT_ADD, 4'd14, 8'h8F, 8'hFF);

        for (int i = 0; i < N_RANDOM; i++) begin
            cmd  = 1'($urandom_range(0, 1));
            mode = $urandom_range(0, 3);
            s    = BYTE_W'($urandom_range(0, 255));
            t    = BYTE_W'($urandom_range(0, 255));
            if (cmd == CMD_FLOAT_ADD && mode == 1) begin
                // unlike signs at one exponent: cancellation and the tie
                e = 3'($urandom_range(0, 7));
                s = {s[7], e, s[3:0]};
                t = {~s[7], e, ($urandom_range(0, 3) == 0) ? s[3:0] : t[3:0]};
            end else if (cmd == CMD_FLOAT_ADD && mode == 2) begin
                // exponents at the far ends
                s[6:4] = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
                t[6:4] = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
            end
            queue_cmd(cmd, IDX_W'($urandom_range(0, 15)), s, t);
        end

        while (!i_rst_n)
            @(posedge i_clk);
        while (pending_cmds.size() != 0 || predicted_sums.size() != 0)
            @(posedge i_clk);
        // a stray strobe after the last result would show up here
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (predicted_sums.size() != 0) begin
            $error("%0d results never arrived", predicted_sums.size());
            n_failures++;
        end

        $display("run covered %0d integer and %0d float adds, %0d results compared",
                 n_int, n_float, n_checked);
        if (n_failures == 0)
            $display("** byte_int_and_minifloat_adder_top: PASSED **");
        else
            $display("** byte_int_and_minifloat_adder_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
